// ===== hw/rtl/wheel_slowdown_mode_supervisor_defines.svh =====
// Assertion macros for the wheel slowdown mode supervisor checker.
// Depends on nothing; the asserting scope must provide i_clk and i_rst_n.
`ifndef WHEEL_SLOWDOWN_MODE_SUPERVISOR_DEFINES_SVH
`define WHEEL_SLOWDOWN_MODE_SUPERVISOR_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define WSMS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wsms: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define WSMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wsms: next-cycle check failed");

`endif

// ===== hw/rtl/wsms_pkg.sv =====
// Shared types and constants of the wheel slowdown mode supervisor.
// No dependencies.
package wsms_pkg;

    localparam int TICKS_PER_SECOND_DEF = 10;

    localparam int SPEED_W     = 16;
    localparam int RATIO_W     = 16;
    localparam int ACC_W       = 32;
    localparam int CNT_W       = 16;
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int RATIO_FRAC  = 12;
    localparam int FILT_SHIFT  = 16;

    // multiplier operand taken four bits a cycle
    localparam int DIGIT_W     = 4;
    localparam int N_DIGITS    = RATIO_W / DIGIT_W;
    localparam int DIGIT_CNT_W = $clog2(N_DIGITS);

    localparam logic [RATIO_W-1:0] SLOW_RATIO_RST    = 16'd2048;
    localparam logic [RATIO_W-1:0] RECOVER_RATIO_RST = 16'd3686;
    localparam logic [RATIO_W-1:0] FILTER_WEIGHT_RST = 16'd6554;
    localparam logic [CNT_W-1:0]   COUNT_LIMIT_RST   = 16'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOW_RATIO    = 3'd0,
        CFG_RECOVER_RATIO = 3'd1,
        CFG_FILTER_WEIGHT = 3'd2,
        CFG_ACCEL_THR     = 3'd3,
        CFG_SLOW_LIMIT    = 3'd4,
        CFG_RECOVER_LIMIT = 3'd5,
        CFG_NORMAL_CRUISE = 3'd6,
        CFG_SLOW_CRUISE   = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_MUL,
        S_FILT,
        S_DEC
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_mac_ctrl;

endpackage

// ===== hw/rtl/wsms_mac.sv =====
// Digit-serial signed-by-unsigned multiplier lane, MSB digit first.
// Depends on wsms_pkg.
module wsms_mac
    import wsms_pkg::*;
#(
    parameter int MCAND_W = SPEED_W
) (
    input  logic                                i_clk,
    input  t_mac_ctrl                           i_ctrl,
    input  logic signed [MCAND_W-1:0]           i_mcand,
    input  logic        [RATIO_W-1:0]           i_mult,
    output logic signed [MCAND_W+RATIO_W-1:0]   o_prod
);

    localparam int PROD_W = MCAND_W + RATIO_W;
    localparam int PP_W   = MCAND_W + DIGIT_W + 1;

    logic signed [MCAND_W-1:0] r_mcand;
    logic        [RATIO_W-1:0] r_mult;
    logic signed [PROD_W-1:0]  r_acc;
    logic signed [PROD_W-1:0]  n_acc;
    logic        [DIGIT_W-1:0] w_digit;
    logic signed [PP_W-1:0]    w_pp;

    assign w_digit = r_mult[RATIO_W-1 -: DIGIT_W];
    assign w_pp    = r_mcand * $signed({1'b0, w_digit});
    assign n_acc   = (r_acc <<< DIGIT_W) + {{(PROD_W-PP_W){w_pp[PP_W-1]}}, w_pp};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_mcand <= i_mcand;
            r_mult  <= i_mult;
            r_acc   <= '0;
        end else if (i_ctrl.step) begin
            r_mult  <= r_mult << DIGIT_W;
            r_acc   <= n_acc;
        end
    end

    assign o_prod = r_acc;

endmodule

// ===== hw/rtl/wheel_slowdown_mode_supervisor.sv =====
// Wheel slowdown mode supervisor: top level, sequencer, filters and mode logic.
// Depends on wsms_pkg and wsms_mac (four digit-serial multiplier lanes).
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-------------------------------------------
//  input     | i_in_valid / o_in_stall   | left/right speed, left/right target
//  output    | o_out_valid / i_out_stall | slow_mode, cruise_speed, reset_integrals
//  config    | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// A request goes through accept, operand set-up, four multiply digits,
// filter/counter update and mode decision, in that order.
// The result sits in an output register; the next request is taken as soon as
// the decision is done, and the decision waits only if a result is still stalled.
// Reset is synchronous, active low: registers to defaults, state to zero, normal mode.
module wheel_slowdown_mode_supervisor
    import wsms_pkg::*;
#(
    parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_W-1:0]           i_cfg_data,
    // requests in
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SPEED_W-1:0]  i_left_speed,
    input  logic signed [SPEED_W-1:0]  i_right_speed,
    input  logic signed [SPEED_W-1:0]  i_left_target,
    input  logic signed [SPEED_W-1:0]  i_right_target,
    // results out
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_slow_mode,
    output logic signed [SPEED_W-1:0]  o_cruise_speed,
    output logic                       o_reset_integrals
);

    // widths of the acceleration path
    localparam int TPS_W   = $clog2(TICKS_PER_SECOND + 1);
    localparam int DSPD_W  = SPEED_W + 1;
    localparam int ACCEL_W = DSPD_W + TPS_W;
    localparam int FDIFF_W = ACC_W + 1;
    localparam int FPROD_W = FDIFF_W + RATIO_W;
    localparam int TPROD_W = SPEED_W + RATIO_W;

    localparam logic [TPS_W-1:0]          TPS_U      = TPS_W'(TICKS_PER_SECOND);
    localparam logic signed [FPROD_W-1:0] FILT_ROUND = FPROD_W'(2 ** (FILT_SHIFT - 1));
    localparam logic [DIGIT_CNT_W-1:0]    DIGIT_LAST = DIGIT_CNT_W'(N_DIGITS - 1);

    // saturate a filter sum (two guard bits) to the accumulator range
    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W+1:0] v);
        logic signed [ACC_W-1:0] res;
        if ((v[ACC_W+1] == v[ACC_W]) && (v[ACC_W] == v[ACC_W-1])) begin
            res = v[ACC_W-1:0];
        end else if (v[ACC_W+1]) begin
            res = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(ACC_W-1){1'b1}}};
        end
        return res;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c != '1) ? c + 1'b1 : c;
    endfunction

    // ---------------------------------------------------------------- config
    logic        [RATIO_W-1:0] r_slow_ratio;
    logic        [RATIO_W-1:0] r_recover_ratio;
    logic        [RATIO_W-1:0] r_filter_weight;
    logic signed [ACC_W-1:0]   r_accel_thr;
    logic        [CNT_W-1:0]   r_slow_limit;
    logic        [CNT_W-1:0]   r_recover_limit;
    logic signed [SPEED_W-1:0] r_normal_cruise;
    logic signed [SPEED_W-1:0] r_slow_cruise;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow_ratio    <= SLOW_RATIO_RST;
            r_recover_ratio <= RECOVER_RATIO_RST;
            r_filter_weight <= FILTER_WEIGHT_RST;
            r_accel_thr     <= '0;
            r_slow_limit    <= COUNT_LIMIT_RST;
            r_recover_limit <= COUNT_LIMIT_RST;
            r_normal_cruise <= '0;
            r_slow_cruise   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SLOW_RATIO:    r_slow_ratio    <= i_cfg_data[RATIO_W-1:0];
                CFG_RECOVER_RATIO: r_recover_ratio <= i_cfg_data[RATIO_W-1:0];
                CFG_FILTER_WEIGHT: r_filter_weight <= i_cfg_data[RATIO_W-1:0];
                CFG_ACCEL_THR:     r_accel_thr     <= i_cfg_data[ACC_W-1:0];
                CFG_SLOW_LIMIT:    r_slow_limit    <= i_cfg_data[CNT_W-1:0];
                CFG_RECOVER_LIMIT: r_recover_limit <= i_cfg_data[CNT_W-1:0];
                CFG_NORMAL_CRUISE: r_normal_cruise <= i_cfg_data[SPEED_W-1:0];
                CFG_SLOW_CRUISE:   r_slow_cruise   <= i_cfg_data[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- sequencer
    t_state                   r_state;
    t_state                   n_state;
    logic [DIGIT_CNT_W-1:0]   r_digit;
    t_mac_ctrl                w_mac_ctrl;
    logic                     w_accept;
    logic                     w_dec_go;
    logic                     r_out_valid;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    // decision may only retire once the output register is free
    assign w_dec_go   = (r_state == S_DEC) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_digit <= '0;
        end else begin
            r_state <= n_state;
            r_digit <= (r_state == S_MUL) ? r_digit + 1'b1 : '0;
        end
    end

    always_comb begin
        n_state    = r_state;
        w_mac_ctrl = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                w_mac_ctrl.load = 1'b1;
                n_state         = S_MUL;
            end
            S_MUL: begin
                w_mac_ctrl.step = 1'b1;
                if (r_digit == DIGIT_LAST) begin
                    n_state = S_FILT;
                end
            end
            S_FILT: begin
                n_state = S_DEC;
            end
            S_DEC: begin
                if (w_dec_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- request capture
    // r_left_speed/r_right_speed double as the previous-tick speeds.
    logic signed [SPEED_W-1:0] r_left_speed;
    logic signed [SPEED_W-1:0] r_right_speed;
    logic signed [SPEED_W-1:0] r_left_target;
    logic signed [SPEED_W-1:0] r_right_target;
    logic signed [ACCEL_W-1:0] r_accel_l;
    logic signed [ACCEL_W-1:0] r_accel_r;
    logic signed [DSPD_W-1:0]  w_dspd_l;
    logic signed [DSPD_W-1:0]  w_dspd_r;
    logic signed [ACCEL_W-1:0] w_accel_l;
    logic signed [ACCEL_W-1:0] w_accel_r;

    assign w_dspd_l  = {i_left_speed[SPEED_W-1], i_left_speed}
                     - {r_left_speed[SPEED_W-1], r_left_speed};
    assign w_dspd_r  = {i_right_speed[SPEED_W-1], i_right_speed}
                     - {r_right_speed[SPEED_W-1], r_right_speed};
    assign w_accel_l = w_dspd_l * $signed({1'b0, TPS_U});
    assign w_accel_r = w_dspd_r * $signed({1'b0, TPS_U});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_speed  <= '0;
            r_right_speed <= '0;
        end else if (w_accept) begin
            r_left_speed  <= i_left_speed;
            r_right_speed <= i_right_speed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_left_target  <= i_left_target;
            r_right_target <= i_right_target;
            r_accel_l      <= w_accel_l;
            r_accel_r      <= w_accel_r;
        end
    end

    // ---------------------------------------------------------------- multiplier lanes
    // Targets scaled by the ratio of the current mode; filter step is w * (a - f).
    logic signed [ACC_W-1:0]   r_filt_l;
    logic signed [ACC_W-1:0]   r_filt_r;
    logic        [RATIO_W-1:0] w_ratio;
    logic signed [FDIFF_W-1:0] w_fdiff_l;
    logic signed [FDIFF_W-1:0] w_fdiff_r;
    logic signed [TPROD_W-1:0] w_tprod_l;
    logic signed [TPROD_W-1:0] w_tprod_r;
    logic signed [FPROD_W-1:0] w_fprod_l;
    logic signed [FPROD_W-1:0] w_fprod_r;
    logic                      r_mode_slow;

    assign w_ratio   = r_mode_slow ? r_recover_ratio : r_slow_ratio;
    assign w_fdiff_l = {{(FDIFF_W-ACCEL_W){r_accel_l[ACCEL_W-1]}}, r_accel_l}
                     - {r_filt_l[ACC_W-1], r_filt_l};
    assign w_fdiff_r = {{(FDIFF_W-ACCEL_W){r_accel_r[ACCEL_W-1]}}, r_accel_r}
                     - {r_filt_r[ACC_W-1], r_filt_r};

    wsms_mac #(.MCAND_W(SPEED_W)) u_mac_tl (
        .i_clk   (i_clk),
        .i_ctrl  (w_mac_ctrl),
        .i_mcand (r_left_target),
        .i_mult  (w_ratio),
        .o_prod  (w_tprod_l)
    );

    wsms_mac #(.MCAND_W(SPEED_W)) u_mac_tr (
        .i_clk   (i_clk),
        .i_ctrl  (w_mac_ctrl),
        .i_mcand (r_right_target),
        .i_mult  (w_ratio),
        .o_prod  (w_tprod_r)
    );

    wsms_mac #(.MCAND_W(FDIFF_W)) u_mac_fl (
        .i_clk   (i_clk),
        .i_ctrl  (w_mac_ctrl),
        .i_mcand (w_fdiff_l),
        .i_mult  (r_filter_weight),
        .o_prod  (w_fprod_l)
    );

    wsms_mac #(.MCAND_W(FDIFF_W)) u_mac_fr (
        .i_clk   (i_clk),
        .i_ctrl  (w_mac_ctrl),
        .i_mcand (w_fdiff_r),
        .i_mult  (r_filter_weight),
        .o_prod  (w_fprod_r)
    );

    // ---------------------------------------------------------------- filter and counters
    logic signed [TPROD_W-1:0] w_lhs_l;
    logic signed [TPROD_W-1:0] w_lhs_r;
    logic                      w_cnt_cond;
    logic signed [FPROD_W-1:0] w_fsum_l;
    logic signed [FPROD_W-1:0] w_fsum_r;
    logic signed [FDIFF_W-1:0] w_fstep_l;
    logic signed [FDIFF_W-1:0] w_fstep_r;
    logic signed [ACC_W+1:0]   w_fnew_l;
    logic signed [ACC_W+1:0]   w_fnew_r;
    logic        [CNT_W-1:0]   r_slowing;
    logic        [CNT_W-1:0]   r_recovered;
    logic                      r_cond;

    // speed scaled up by the ratio's fraction bits, compared exactly
    assign w_lhs_l = {{(TPROD_W-SPEED_W-RATIO_FRAC){r_left_speed[SPEED_W-1]}},
                      r_left_speed, {RATIO_FRAC{1'b0}}};
    assign w_lhs_r = {{(TPROD_W-SPEED_W-RATIO_FRAC){r_right_speed[SPEED_W-1]}},
                      r_right_speed, {RATIO_FRAC{1'b0}}};

    // slow mode: both wheels recovered; normal mode: either wheel slowing
    assign w_cnt_cond = r_mode_slow ? ((w_lhs_l > w_tprod_l) && (w_lhs_r > w_tprod_r))
                                    : ((w_lhs_l < w_tprod_l) || (w_lhs_r < w_tprod_r));

    // round half up, then floor shift
    assign w_fsum_l  = w_fprod_l + FILT_ROUND;
    assign w_fsum_r  = w_fprod_r + FILT_ROUND;
    assign w_fstep_l = w_fsum_l[FPROD_W-1:FILT_SHIFT];
    assign w_fstep_r = w_fsum_r[FPROD_W-1:FILT_SHIFT];
    assign w_fnew_l  = {{2{r_filt_l[ACC_W-1]}}, r_filt_l}
                     + {w_fstep_l[FDIFF_W-1], w_fstep_l};
    assign w_fnew_r  = {{2{r_filt_r[ACC_W-1]}}, r_filt_r}
                     + {w_fstep_r[FDIFF_W-1], w_fstep_r};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt_l    <= '0;
            r_filt_r    <= '0;
            r_slowing   <= '0;
            r_recovered <= '0;
            r_cond      <= 1'b0;
        end else if (r_state == S_FILT) begin
            r_filt_l <= sat_acc(w_fnew_l);
            r_filt_r <= sat_acc(w_fnew_r);
            r_cond   <= w_cnt_cond;
            // each counter only moves in its own mode, never cleared on a change
            if (r_mode_slow) begin
                r_recovered <= w_cnt_cond ? sat_inc(r_recovered) : '0;
            end else begin
                r_slowing   <= w_cnt_cond ? sat_inc(r_slowing) : '0;
            end
        end
    end

    // ---------------------------------------------------------------- mode decision
    logic                      w_blocked;
    logic                      w_to_slow;
    logic                      w_to_normal;
    logic                      w_change;
    logic signed [SPEED_W-1:0] w_new_cruise;
    logic                      w_pulse;
    logic signed [SPEED_W-1:0] r_cruise;
    logic                      r_out_slow;
    logic signed [SPEED_W-1:0] r_out_cruise;
    logic                      r_out_pulse;

    // both filtered accelerations above threshold hold off slow mode
    assign w_blocked    = (r_filt_l > r_accel_thr) && (r_filt_r > r_accel_thr);
    assign w_to_slow    = !r_mode_slow && !w_blocked && (r_slowing > r_slow_limit) && r_cond;
    assign w_to_normal  = r_mode_slow && (r_recovered > r_recover_limit);
    assign w_change     = w_to_slow || w_to_normal;
    assign w_new_cruise = w_to_slow ? r_slow_cruise : r_normal_cruise;
    // integral reset only when the change lowers the cruise speed
    assign w_pulse      = w_change && (r_cruise > w_new_cruise);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_slow <= 1'b0;
            r_cruise    <= '0;
        end else if (w_dec_go && w_change) begin
            r_mode_slow <= !r_mode_slow;
            r_cruise    <= w_new_cruise;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_dec_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_dec_go) begin
            r_out_slow   <= w_change ? !r_mode_slow : r_mode_slow;
            r_out_cruise <= w_change ? w_new_cruise : r_cruise;
            r_out_pulse  <= w_pulse;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_slow_mode       = r_out_slow;
    assign o_cruise_speed    = r_out_cruise;
    assign o_reset_integrals = r_out_pulse;

endmodule

// ===== hw/rtl/wsms_checker.sv =====
// Port-level checker for the wheel slowdown mode supervisor, bound to the top level.
// Depends on wheel_slowdown_mode_supervisor_defines.svh.
`include "wheel_slowdown_mode_supervisor_defines.svh"

module wsms_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_cfg_we,
    input logic [2:0]         i_cfg_index,
    input logic [31:0]        i_cfg_data,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic signed [15:0] i_left_speed,
    input logic signed [15:0] i_right_speed,
    input logic signed [15:0] i_left_target,
    input logic signed [15:0] i_right_target,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic               o_slow_mode,
    input logic signed [15:0] o_cruise_speed,
    input logic               o_reset_integrals
);

    // a stalled result holds
    `WSMS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_slow_mode) && $stable(o_cruise_speed) && $stable(o_reset_integrals))

    // one request at a time: busy straight after an accept
    `WSMS_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)

    // a fresh result only comes out of a busy block
    `WSMS_ASSERT_SAME(a_result_from_work, $rose(o_out_valid), $past(o_in_stall))

endmodule

bind wheel_slowdown_mode_supervisor wsms_checker u_wsms_checker (.*);
